FILE: hw/rtl/dmd_pkg.sv
package dmd_pkg;

	localparam int VAL_W  = 31;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 10;

	localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IW-1:0] REG_RADIUS = 2'd2;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             col_first;
		logic             col_last;
		logic             row_first;
		logic             row_last;
	} pix_t;

	typedef struct packed {
		pix_t cur;
		pix_t up;
	} line_t;

	typedef struct packed {
		logic adv;
		logic clr;
		logic bypass;
	} cell_ctrl_t;

endpackage

FILE: hw/rtl/dmd_cell.sv
module dmd_cell #(
	parameter int DEPTH = 512
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  dmd_pkg::cell_ctrl_t                           ctrl,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] line_len_m1,
	input  dmd_pkg::pix_t                                 din,
	output dmd_pkg::pix_t                                 dout
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	function automatic logic [dmd_pkg::VAL_W-1:0] vmax(
		input logic [dmd_pkg::VAL_W-1:0] a,
		input logic [dmd_pkg::VAL_W-1:0] b
	);
		vmax = (a > b) ? a : b;
	endfunction

	dmd_pkg::line_t mem [DEPTH];
	dmd_pkg::line_t rd_q;
	dmd_pkg::pix_t  below_q;
	dmd_pkg::pix_t  ctr_q;
	dmd_pkg::pix_t  left_q;
	logic [AW-1:0]  ptr_q;

	logic [dmd_pkg::VAL_W-1:0] v_left;
	logic [dmd_pkg::VAL_W-1:0] v_right;
	logic [dmd_pkg::VAL_W-1:0] v_up;
	logic [dmd_pkg::VAL_W-1:0] v_down;
	logic [dmd_pkg::VAL_W-1:0] m_a;
	logic [dmd_pkg::VAL_W-1:0] m_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (ctrl.clr) begin
			ptr_q <= '0;
		end else if (ctrl.adv) begin
			ptr_q <= (ptr_q >= line_len_m1 - AW'(1)) ? '0 : ptr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			mem[ptr_q] <= '{cur: din, up: ctr_q};
			if (ctrl.bypass) begin
				rd_q <= '{cur: din, up: ctr_q};
			end else begin
				rd_q <= mem[ptr_q];
			end
			below_q <= din;
			ctr_q   <= rd_q.cur;
			left_q  <= ctr_q;
		end
	end

	always_comb begin
		v_left  = ctr_q.col_first ? '0 : left_q.value;
		v_right = ctr_q.col_last  ? '0 : rd_q.cur.value;
		v_up    = ctr_q.row_first ? '0 : rd_q.up.value;
		v_down  = ctr_q.row_last  ? '0 : below_q.value;
		m_a     = vmax(ctr_q.value, v_left);
		m_b     = vmax(v_right, v_up);
		dout           = ctr_q;
		dout.value     = vmax(vmax(m_a, m_b), v_down);
	end

endmodule

FILE: hw/rtl/diamond_max_dilation.sv
// Grayscale dilation of a raster-order image with a diamond of Manhattan radius.
// Input beats arrive on s_axis: tdata carries the signed 32-bit pixel, tuser[0]
// marks a drain beat sent after the frame's pixels. Each output beat on m_axis
// carries max(0, largest in-image pixel within the radius) in tdata[30:0];
// tlast flags the frame's final position, after which the next frame starts.
// The result for raster position q leaves on input beat q + radius*(width+1),
// so radius*(width+1) drain beats follow each frame.
// Throughput is one beat per cycle unless m_axis stalls; the result of an accepted
// beat is registered for the next cycle. Latency in beats is set by the chain of
// cross-max cells, one per unit of radius, each holding two rows in a line RAM.
// Width, height and radius are for the user to write on the cfg channel (index
// 0, 1, 2) while the block is idle (not enforced); a write restarts the frame.
// Reset sets width and height to 512, radius to 1 and starts a new frame; the
// line RAMs hold stale data, which no result reads.
// A stalled receiver holds the output register and deasserts s_axis_tready
// until the waiting beat is taken.
module diamond_max_dilation #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int MAX_RADIUS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [31:0]                   s_axis_tdata,  // pixel_value
	input  logic [0:0]                    s_axis_tuser,  // cmd
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [31:0]                   m_axis_tdata,  // dilated_value, zero pad
	output logic                          m_axis_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dmd_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [dmd_pkg::CFG_DW-1:0]   cfg_data
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
	localparam int TW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * (MAX_WIDTH + 1) + 1);
	localparam int W_RST = (512 > MAX_WIDTH) ? MAX_WIDTH : 512;
	localparam int H_RST = (512 > MAX_HEIGHT) ? MAX_HEIGHT : 512;
	localparam int R_RST = (1 > MAX_RADIUS) ? MAX_RADIUS : 1;

	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [RW-1:0] r_q;
	logic [TW-1:0] t_q;
	logic [AW-1:0] col_q;
	logic [HW-1:0] row_q;
	logic          out_valid_q;
	logic [dmd_pkg::VAL_W-1:0] out_value_q;
	logic          out_last_q;

	logic          accept;
	logic          cfg_wr;
	logic          emit;
	logic          res_last;
	logic [TW-1:0] delay;
	logic [AW-1:0] w_m1;
	dmd_pkg::cell_ctrl_t ctrl;
	dmd_pkg::pix_t       tap [MAX_RADIUS+1];
	dmd_pkg::pix_t       res;

	assign cfg_ready     = 1'b1;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_value_q};
	assign m_axis_tlast  = out_last_q;

	assign cfg_wr = cfg_valid && cfg_ready &&
		(cfg_index == dmd_pkg::REG_WIDTH || cfg_index == dmd_pkg::REG_HEIGHT ||
		 cfg_index == dmd_pkg::REG_RADIUS);

	assign w_m1  = AW'(w_q - WW'(1));
	assign delay = TW'(r_q) * (TW'(w_q) + TW'(1));

	always_comb begin
		tap[0].value     = (s_axis_tuser[0] || s_axis_tdata[31]) ? '0 : s_axis_tdata[30:0];
		tap[0].col_first = (col_q == '0);
		tap[0].col_last  = (col_q == w_m1);
		tap[0].row_first = (row_q == '0);
		tap[0].row_last  = (row_q == HW'(h_q - HW'(1)));
	end

	assign ctrl.adv    = accept;
	assign ctrl.clr    = cfg_wr;
	assign ctrl.bypass = (w_m1 == '0);

	genvar k;
	generate
		for (k = 0; k < MAX_RADIUS; k++) begin : g_cell
			dmd_cell #(
				.DEPTH(MAX_WIDTH)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.line_len_m1 (w_m1),
				.din         (tap[k]),
				.dout        (tap[k+1])
			);
		end
	endgenerate

	assign res      = tap[r_q];
	assign emit     = accept && (t_q >= delay);
	assign res_last = res.row_last && res.col_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(W_RST);
			h_q <= HW'(H_RST);
			r_q <= RW'(R_RST);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dmd_pkg::REG_WIDTH: begin
					if (cfg_data == '0) begin
						w_q <= WW'(1);
					end else if (int'(cfg_data) > MAX_WIDTH) begin
						w_q <= WW'(MAX_WIDTH);
					end else begin
						w_q <= WW'(cfg_data);
					end
				end
				dmd_pkg::REG_HEIGHT: begin
					if (cfg_data == '0) begin
						h_q <= HW'(1);
					end else if (int'(cfg_data) > MAX_HEIGHT) begin
						h_q <= HW'(MAX_HEIGHT);
					end else begin
						h_q <= HW'(cfg_data);
					end
				end
				dmd_pkg::REG_RADIUS: begin
					if (int'(cfg_data[4:0]) > MAX_RADIUS) begin
						r_q <= RW'(MAX_RADIUS);
					end else begin
						r_q <= RW'(cfg_data[4:0]);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q   <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			t_q   <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (emit && res_last) begin
				t_q   <= '0;
				col_q <= '0;
				row_q <= '0;
			end else begin
				t_q <= t_q + TW'(1);
				if (col_q == w_m1) begin
					col_q <= '0;
					row_q <= row_q + HW'(1);
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_value_q <= res.value;
			out_last_q  <= res_last;
		end
	end

	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res_last |=> t_q == '0)
		else $error("frame counter did not restart after the last beat");

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> t_q == '0 && col_q == '0 && row_q == '0)
		else $error("register write did not restart the frame");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(accept))
		else $error("output beat appeared without an accepted input beat");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		accept && t_q < delay |=> !(m_axis_tvalid && !$past(m_axis_tvalid)))
		else $error("result emitted before the window filled");

endmodule
